FILE: rtl/drd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_pkg
// Shared types and constants for the detection row decoder: row layout,
// configuration register indexes, element tags and the result record.
// ----------------------------------------------------------------------------
package drd_pkg;

  // Row layout
  localparam int ROW_LAST     = 21;
  localparam int LOGIT_POS    = 8;
  localparam int COLOUR_FIRST = 9;
  localparam int CLASS_FIRST  = 13;
  localparam int POS_BITS     = 5;

  // Front-to-back queue depth
  localparam int QUEUE_DEPTH = 2;

  // Field widths of the result record
  localparam int BOX_BITS         = 8;
  localparam int CLASS_INDEX_BITS = 4;
  localparam int SCORE_BITS       = 16;

  // Configuration port
  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;
  localparam int FILTER_BITS    = 2;

  localparam logic signed [CFG_DATA_BITS-1:0] THRESHOLD_RESET = 16'sd158;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_THRESHOLD     = 1'b0,
    CFG_COLOUR_FILTER = 1'b1
  } cfg_index_t;

  typedef enum logic [FILTER_BITS-1:0] {
    FILTER_BOTH    = 2'd0,
    FILTER_COLOUR0 = 2'd1,
    FILTER_COLOUR1 = 2'd2
  } colour_filter_t;

  // What an element of a row is, as decided by the front end
  typedef enum logic [3:0] {
    EK_X_FIRST,
    EK_Y_FIRST,
    EK_X,
    EK_Y,
    EK_LOGIT,
    EK_COLOUR_FIRST,
    EK_COLOUR,
    EK_CLASS_FIRST,
    EK_CLASS,
    EK_CLASS_LAST
  } elem_kind_t;

  typedef struct packed {
    elem_kind_t                  kind;
    logic [CLASS_INDEX_BITS-1:0] sub_index;
  } elem_tag_t;

  typedef struct packed {
    logic signed [CFG_DATA_BITS-1:0] threshold;
    logic [FILTER_BITS-1:0]          colour_filter;
  } cfg_t;

  typedef struct packed {
    logic signed [BOX_BITS-1:0]  box_left;
    logic signed [BOX_BITS-1:0]  box_top;
    logic [BOX_BITS-1:0]         box_width;
    logic [BOX_BITS-1:0]         box_height;
    logic [CLASS_INDEX_BITS-1:0] class_index;
    logic signed [SCORE_BITS-1:0] class_score;
    logic                        colour_index;
  } result_t;

endpackage

FILE: rtl/drd_elem_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_elem_if
// Element channel: one signed fixed-point value of a detection row a request.
// ----------------------------------------------------------------------------
interface drd_elem_if #(
  parameter int VALUE_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

FILE: rtl/drd_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_result_if
// Result channel: one decoded detection (box, class, score, colour) a request.
// ----------------------------------------------------------------------------
interface drd_result_if;
  import drd_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [BOX_BITS-1:0]   box_left;
  logic signed [BOX_BITS-1:0]   box_top;
  logic [BOX_BITS-1:0]          box_width;
  logic [BOX_BITS-1:0]          box_height;
  logic [CLASS_INDEX_BITS-1:0]  class_index;
  logic signed [SCORE_BITS-1:0] class_score;
  logic                         colour_index;

  modport source (
    output valid, output box_left, output box_top, output box_width,
    output box_height, output class_index, output class_score,
    output colour_index, input ready
  );
  modport sink (
    input valid, input box_left, input box_top, input box_width,
    input box_height, input class_index, input class_score,
    input colour_index, output ready
  );
endinterface

FILE: rtl/drd_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_cfg_if
// Configuration write channel: register index and write data a request.
// ----------------------------------------------------------------------------
interface drd_cfg_if;
  import drd_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [CFG_DATA_BITS-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/drd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_front
// Front end: tracks the position within a row and tags every accepted
// element with its role (corner, logit, colour, class) and group index.
// ----------------------------------------------------------------------------
module drd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               elem_valid,
  output logic               elem_ready,
  output logic               push_valid,
  input  logic               push_ready,
  output drd_pkg::elem_tag_t push_tag
);
  import drd_pkg::*;

  logic [POS_BITS-1:0] pos;
  logic [POS_BITS-1:0] pos_next;
  logic [POS_BITS-1:0] colour_offset;
  logic [POS_BITS-1:0] class_offset;
  logic                accept;

  // Pass the handshake straight to the queue
  assign elem_ready = push_ready;
  assign push_valid = elem_valid;
  assign accept     = elem_valid && push_ready;

  assign colour_offset = pos - POS_BITS'(COLOUR_FIRST);
  assign class_offset  = pos - POS_BITS'(CLASS_FIRST);

  // Classify the element at the current position
  always_comb begin
    push_tag.kind      = EK_CLASS;
    push_tag.sub_index = '0;
    if (pos < POS_BITS'(LOGIT_POS)) begin
      if (pos < POS_BITS'(2)) begin
        push_tag.kind = pos[0] ? EK_Y_FIRST : EK_X_FIRST;
      end else begin
        push_tag.kind = pos[0] ? EK_Y : EK_X;
      end
    end else if (pos == POS_BITS'(LOGIT_POS)) begin
      push_tag.kind = EK_LOGIT;
    end else if (pos < POS_BITS'(CLASS_FIRST)) begin
      push_tag.kind      = (pos == POS_BITS'(COLOUR_FIRST)) ? EK_COLOUR_FIRST : EK_COLOUR;
      push_tag.sub_index = colour_offset[CLASS_INDEX_BITS-1:0];
    end else begin
      if (pos == POS_BITS'(CLASS_FIRST)) begin
        push_tag.kind = EK_CLASS_FIRST;
      end else if (pos >= POS_BITS'(ROW_LAST)) begin
        push_tag.kind = EK_CLASS_LAST;
      end else begin
        push_tag.kind = EK_CLASS;
      end
      push_tag.sub_index = class_offset[CLASS_INDEX_BITS-1:0];
    end
  end

  // Advance the position, wrap after the last element of a row
  always_comb begin
    pos_next = pos;
    if (accept) begin
      pos_next = (pos >= POS_BITS'(ROW_LAST)) ? '0 : pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

FILE: rtl/drd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_queue
// Short FIFO between front and back end so that each side stalls on its own.
// ----------------------------------------------------------------------------
module drd_queue #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);
  localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]    mem [DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] count;
  logic                push_fire;
  logic                pop_fire;

  assign push_ready = (count != CNT_BITS'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  // Store the request at the write pointer
  always_ff @(posedge clk) begin
    if (push_fire) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push_fire && !pop_fire) begin
        count <= count + 1'b1;
      end else if (pop_fire && !push_fire) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_BITS'(DEPTH))
    else $error("queue occupancy above depth");

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (!rst && push_fire && !pop_fire) |=> count == $past(count) + 1'b1)
    else $error("queue occupancy did not grow on push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    (!rst && pop_fire && !push_fire) |=> count == $past(count) - 1'b1)
    else $error("queue occupancy did not shrink on pop");

endmodule

FILE: rtl/drd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drd_back
// Back end: updates the running box bounds and argmaxes from tagged
// elements, applies the drop rules at a row's end and holds the result.
// ----------------------------------------------------------------------------
module drd_back #(
  parameter int VALUE_BITS    = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         pop_valid,
  output logic                         pop_ready,
  input  drd_pkg::elem_tag_t           pop_tag,
  input  logic signed [VALUE_BITS-1:0] pop_value,
  input  drd_pkg::cfg_t                cfg,
  output logic                         res_valid,
  input  logic                         res_ready,
  output drd_pkg::result_t             res
);
  import drd_pkg::*;

  localparam int XW = ((VALUE_BITS > FRACTION_BITS) ? VALUE_BITS : FRACTION_BITS) + 2;
  localparam int CW = (VALUE_BITS > SCORE_BITS) ? VALUE_BITS : SCORE_BITS;
  localparam int SW = VALUE_BITS + 1;

  localparam logic signed [XW-1:0] ROUND_BIAS = (XW'(1) << FRACTION_BITS) - XW'(1);
  localparam logic signed [XW-1:0] EDGE_MAX   = XW'(127);
  localparam logic signed [XW-1:0] EDGE_MIN   = ~EDGE_MAX;
  localparam logic [SW-1:0]        SIZE_MAX   = SW'(255);
  localparam logic signed [CW-1:0] SCORE_MAX  = CW'(32767);
  localparam logic signed [CW-1:0] SCORE_MIN  = ~SCORE_MAX;

  logic signed [VALUE_BITS-1:0] min_x, max_x, min_y, max_y;
  logic signed [VALUE_BITS-1:0] best_colour_score;
  logic [1:0]                   best_colour_index;
  logic signed [VALUE_BITS-1:0] best_class_score;
  logic [CLASS_INDEX_BITS-1:0]  best_class_index;
  logic                         obj_passed;

  logic                         pop_fire;
  logic                         row_end;
  logic                         colour_take;
  logic                         class_take;
  logic signed [VALUE_BITS-1:0] class_score_now;
  logic [CLASS_INDEX_BITS-1:0]  class_index_now;
  logic signed [CW-1:0]         score_ext;
  logic signed [SCORE_BITS-1:0] score_sat;
  logic [SW-1:0]                width_int;
  logic [SW-1:0]                height_int;
  logic                         filter_ok;
  logic                         keep;
  logic                         logit_pass;

  // Truncate a fixed-point edge toward zero and saturate to the box range
  function automatic logic signed [BOX_BITS-1:0] to_edge(
    input logic signed [VALUE_BITS-1:0] q
  );
    logic signed [XW-1:0] ext;
    logic signed [XW-1:0] adj;
    logic signed [XW-1:0] int_val;
    ext     = XW'(q);
    adj     = ext + (q[VALUE_BITS-1] ? ROUND_BIAS : '0);
    int_val = adj >>> FRACTION_BITS;
    if (int_val > EDGE_MAX) begin
      int_val = EDGE_MAX;
    end else if (int_val < EDGE_MIN) begin
      int_val = EDGE_MIN;
    end
    return int_val[BOX_BITS-1:0];
  endfunction

  // Integer part of a nonnegative span
  function automatic logic [SW-1:0] to_span(
    input logic signed [VALUE_BITS-1:0] hi,
    input logic signed [VALUE_BITS-1:0] lo
  );
    logic [SW-1:0] diff;
    diff = {hi[VALUE_BITS-1], hi} - {lo[VALUE_BITS-1], lo};
    return diff >> FRACTION_BITS;
  endfunction

  // Stall the queue only when a row end would meet a full result register
  assign pop_ready = (pop_tag.kind != EK_CLASS_LAST) || !res_valid || res_ready;
  assign pop_fire  = pop_valid && pop_ready;
  assign row_end   = pop_fire && (pop_tag.kind == EK_CLASS_LAST);

  assign colour_take = (pop_tag.kind == EK_COLOUR_FIRST) || (pop_value > best_colour_score);
  assign class_take  = (pop_tag.kind == EK_CLASS_FIRST) || (pop_value > best_class_score);
  assign class_score_now = class_take ? pop_value : best_class_score;
  assign class_index_now = class_take ? pop_tag.sub_index : best_class_index;
  assign logit_pass = !(CW'(pop_value) < CW'(cfg.threshold));

  // Saturate the class score to the result width
  always_comb begin
    score_ext = CW'(class_score_now);
    if (score_ext > SCORE_MAX) begin
      score_ext = SCORE_MAX;
    end else if (score_ext < SCORE_MIN) begin
      score_ext = SCORE_MIN;
    end
    score_sat = score_ext[SCORE_BITS-1:0];
  end

  assign width_int  = to_span(max_x, min_x);
  assign height_int = to_span(max_y, min_y);

  // Drop rules at the row's end
  always_comb begin
    case (cfg.colour_filter)
      FILTER_COLOUR0: filter_ok = !best_colour_index[0];
      FILTER_COLOUR1: filter_ok = best_colour_index[0];
      default:        filter_ok = 1'b1;
    endcase
    keep = obj_passed && !best_colour_index[1] && filter_ok &&
           (width_int != '0) && (height_int != '0);
  end

  // Update running bounds and argmaxes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_x             <= '0;
      max_x             <= '0;
      min_y             <= '0;
      max_y             <= '0;
      obj_passed        <= 1'b0;
      best_colour_score <= '0;
      best_colour_index <= '0;
      best_class_score  <= '0;
      best_class_index  <= '0;
    end else if (pop_fire) begin
      case (pop_tag.kind)
        EK_X_FIRST: begin
          min_x <= pop_value;
          max_x <= pop_value;
        end
        EK_Y_FIRST: begin
          min_y <= pop_value;
          max_y <= pop_value;
        end
        EK_X: begin
          if (pop_value < min_x) min_x <= pop_value;
          if (pop_value > max_x) max_x <= pop_value;
        end
        EK_Y: begin
          if (pop_value < min_y) min_y <= pop_value;
          if (pop_value > max_y) max_y <= pop_value;
        end
        EK_LOGIT: begin
          obj_passed <= logit_pass;
        end
        EK_COLOUR_FIRST, EK_COLOUR: begin
          if (colour_take) begin
            best_colour_score <= pop_value;
            best_colour_index <= pop_tag.sub_index[1:0];
          end
        end
        EK_CLASS_FIRST, EK_CLASS, EK_CLASS_LAST: begin
          best_class_score <= class_score_now;
          best_class_index <= class_index_now;
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (row_end && keep) begin
        res_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (row_end && keep) begin
      res.box_left     <= to_edge(min_x);
      res.box_top      <= to_edge(min_y);
      res.box_width    <= (width_int > SIZE_MAX) ? '1 : width_int[BOX_BITS-1:0];
      res.box_height   <= (height_int > SIZE_MAX) ? '1 : height_int[BOX_BITS-1:0];
      res.class_index  <= class_index_now;
      res.class_score  <= score_sat;
      res.colour_index <= best_colour_index[0];
    end
  end

  a_corners_ordered: assert property (@(posedge clk) disable iff (rst)
    (pop_fire && pop_tag.kind == EK_LOGIT) |-> (min_x <= max_x) && (min_y <= max_y))
    else $error("corner bounds out of order after corners");

  a_box_nonempty: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.box_width != '0) && (res.box_height != '0))
    else $error("empty box emitted");

  a_filter_colour0: assert property (@(posedge clk) disable iff (rst)
    (res_valid && cfg.colour_filter == FILTER_COLOUR0) |-> !res.colour_index)
    else $error("colour filter let colour one through");

  a_filter_colour1: assert property (@(posedge clk) disable iff (rst)
    (res_valid && cfg.colour_filter == FILTER_COLOUR1) |-> res.colour_index)
    else $error("colour filter let colour zero through");

endmodule

FILE: rtl/detection_row_decoder.sv
`timescale 1ns / 1ps
// Result path: with an empty queue, the row's last element is written to the
// queue, popped by the back end and held in the result register until taken.
// Throughput: one element per cycle, as long as results are taken when offered;
// the 2-entry front/back queue and the result register carry short stalls.
// A row end can only retire when the result register is free or being taken.
// Reset: row position, running bounds and argmaxes clear; threshold is 158,
// colour filter keeps both colours.
// ----------------------------------------------------------------------------
// detection_row_decoder
// Decodes streamed detector rows into box, class, score and colour results,
// dropping rows by objectness threshold, colour, colour filter and box size.
// ----------------------------------------------------------------------------
module detection_row_decoder #(
  parameter int VALUE_BITS    = 16,
  parameter int FRACTION_BITS = 8
) (
  input logic           clk,
  input logic           rst,
  drd_elem_if.sink      elem,
  drd_result_if.source  result,
  drd_cfg_if.sink       cfg
);
  import drd_pkg::*;

  localparam int TAG_BITS = $bits(elem_tag_t);
  localparam int QW       = TAG_BITS + VALUE_BITS;

  cfg_t                         cfg_regs;
  elem_tag_t                    push_tag;
  logic                         push_valid;
  logic                         push_ready;
  logic [QW-1:0]                pop_data;
  logic                         pop_valid;
  logic                         pop_ready;
  elem_tag_t                    pop_tag;
  logic signed [VALUE_BITS-1:0] pop_value;
  logic                         res_valid;
  result_t                      res;

  // Configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.threshold     <= THRESHOLD_RESET;
      cfg_regs.colour_filter <= FILTER_BOTH;
    end else if (cfg.valid) begin
      case (cfg_index_t'(cfg.index))
        CFG_THRESHOLD:     cfg_regs.threshold     <= cfg.data;
        CFG_COLOUR_FILTER: cfg_regs.colour_filter <= cfg.data[FILTER_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front end: position and classification
  drd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .elem_valid (elem.valid),
    .elem_ready (elem.ready),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_tag   (push_tag)
  );

  // Decoupling queue
  drd_queue #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  ({push_tag, elem.element_value}),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  assign pop_tag   = elem_tag_t'(pop_data[QW-1 -: TAG_BITS]);
  assign pop_value = $signed(pop_data[VALUE_BITS-1:0]);

  // Back end: accumulate and emit
  drd_back #(
    .VALUE_BITS    (VALUE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_tag   (pop_tag),
    .pop_value (pop_value),
    .cfg       (cfg_regs),
    .res_valid (res_valid),
    .res_ready (result.ready),
    .res       (res)
  );

  // Drive the result channel
  assign result.valid        = res_valid;
  assign result.box_left     = res.box_left;
  assign result.box_top      = res.box_top;
  assign result.box_width    = res.box_width;
  assign result.box_height   = res.box_height;
  assign result.class_index  = res.class_index;
  assign result.class_score  = res.class_score;
  assign result.colour_index = res.colour_index;

endmodule
